FILE: hdl/countdown_timer_with_digit_set_core_macros.svh
// assertion macros for the countdown timer checker
// no dependencies; included by files that carry assertions
`ifndef COUNTDOWN_TIMER_WITH_DIGIT_SET_CORE_MACROS_SVH
`define COUNTDOWN_TIMER_WITH_DIGIT_SET_CORE_MACROS_SVH

// property checked at every rising edge outside reset
`define CTDN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising edge, reset included
`define CTDN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ctdn_pkg.sv
// types and constants shared by the countdown timer modules
// no dependencies
`default_nettype none

package ctdn_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_PAUSE = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;

  // set step codes
  localparam logic [2:0] STEP_HUN_ONES = 3'd1;
  localparam logic [2:0] STEP_HUN_TENS = 3'd2;
  localparam logic [2:0] STEP_SEC_ONES = 3'd3;
  localparam logic [2:0] STEP_SEC_TENS = 3'd4;
  localparam logic [2:0] STEP_MIN_ONES = 3'd5;
  localparam logic [2:0] STEP_MIN_TENS = 3'd6;
  localparam logic [2:0] STEP_MAX      = 3'd7;

  // led patterns
  localparam logic [7:0] LED_PAUSED   = 8'h01;
  localparam logic [7:0] LED_HUN_ONES = 8'h02;
  localparam logic [7:0] LED_HUN_TENS = 8'h04;
  localparam logic [7:0] LED_SEC_ONES = 8'h08;
  localparam logic [7:0] LED_SEC_TENS = 8'h10;
  localparam logic [7:0] LED_MIN_ONES = 8'h20;
  localparam logic [7:0] LED_MIN_TENS = 8'h40;
  localparam logic [7:0] LED_RUNNING  = 8'h80;

  // digit limits and reload values
  localparam logic [9:0]  DIGIT_MAX     = 10'd9;
  localparam logic [14:0] HUN_TENS_MAX  = 15'd99;
  localparam logic [14:0] SIXTY_MAX     = 15'd59;
  localparam logic [6:0]  HUN_RELOAD    = 7'd100;
  localparam logic [5:0]  SEC_RELOAD    = 6'd59;

  typedef struct packed {
    logic [1:0] command;
    logic [9:0] switch_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0] minutes_left;
    logic [5:0] seconds_left;
    logic [6:0] hundredths_left;
    logic [7:0] led_pattern;
    logic       running_flag;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    logic       paused;
    logic [2:0] set_step;
    logic [6:0] hundredths;
    logic [5:0] secs;
    logic [5:0] mins;
    logic [7:0] leds;
  } timer_state_t;

endpackage

`default_nettype wire

FILE: hdl/ctdn_in_stage.sv
// input register stage of the countdown timer
// depends on ctdn_pkg
`default_nettype none

module ctdn_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ctdn_pkg::in_item_t in_data,
  input  wire logic              advance,
  output ctdn_pkg::stage_t       stage
);
  import ctdn_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

`default_nettype wire

FILE: hdl/ctdn_update.sv
// next timer state for one item: tick, pause/resume or digit set
// depends on ctdn_pkg
`default_nettype none

module ctdn_update (
  input  wire ctdn_pkg::timer_state_t cur,
  input  wire ctdn_pkg::in_item_t     item,
  output ctdn_pkg::timer_state_t      nxt
);
  import ctdn_pkg::*;

  // one hundredth off, borrowing from seconds or minutes
  function automatic timer_state_t decrement(input timer_state_t s);
    timer_state_t r;
    r = s;
    if (s.hundredths != 7'd0) begin
      r.hundredths = s.hundredths - 7'd1;
      if (r.hundredths == 7'd0 && (s.secs != 6'd0 || s.mins != 6'd0)) begin
        if (s.secs != 6'd0) begin
          r.secs = s.secs - 6'd1;
        end else begin
          r.mins = s.mins - 6'd1;
          r.secs = SEC_RELOAD;
        end
        r.hundredths = HUN_RELOAD;
      end
    end
    return r;
  endfunction

  logic [2:0]  step_n;
  logic [14:0] sw_x10;
  logic [14:0] hun_sum;
  logic [14:0] sec_sum;
  logic [14:0] min_sum;
  logic [6:0]  sw_ones;

  assign step_n  = (cur.set_step == STEP_MAX) ? STEP_MAX : cur.set_step + 3'd1;
  assign sw_x10  = ({5'd0, item.switch_value} << 3) + ({5'd0, item.switch_value} << 1);
  assign hun_sum = {8'd0, cur.hundredths} + sw_x10;
  assign sec_sum = {9'd0, cur.secs} + sw_x10;
  assign min_sum = {9'd0, cur.mins} + sw_x10;
  assign sw_ones = (item.switch_value > DIGIT_MAX) ? DIGIT_MAX[6:0]
                                                   : item.switch_value[6:0];

  always_comb begin
    nxt = cur;
    case (item.command)
      CMD_TICK: begin
        if (!cur.paused) begin
          nxt = decrement(cur);
        end
      end
      CMD_PAUSE: begin
        if (!cur.paused) begin
          nxt.paused = 1'b1;
          nxt.leds   = LED_PAUSED;
        end else begin
          nxt          = decrement(cur);
          nxt.paused   = 1'b0;
          nxt.set_step = 3'd0;
          nxt.leds     = LED_RUNNING;
        end
      end
      CMD_SET: begin
        if (cur.paused) begin
          nxt.set_step = step_n;
          case (step_n)
            STEP_HUN_ONES: begin
              nxt.hundredths = sw_ones;
              nxt.leds       = LED_HUN_ONES;
            end
            STEP_HUN_TENS: begin
              nxt.hundredths = (hun_sum > HUN_TENS_MAX) ? HUN_TENS_MAX[6:0] : hun_sum[6:0];
              nxt.leds       = LED_HUN_TENS;
            end
            STEP_SEC_ONES: begin
              nxt.secs = sw_ones[5:0];
              nxt.leds = LED_SEC_ONES;
            end
            STEP_SEC_TENS: begin
              nxt.secs = (sec_sum > SIXTY_MAX) ? SIXTY_MAX[5:0] : sec_sum[5:0];
              nxt.leds = LED_SEC_TENS;
            end
            STEP_MIN_ONES: begin
              nxt.mins = sw_ones[5:0];
              nxt.leds = LED_MIN_ONES;
            end
            STEP_MIN_TENS: begin
              nxt.mins = (min_sum > SIXTY_MAX) ? SIXTY_MAX[5:0] : min_sum[5:0];
              nxt.leds = LED_MIN_TENS;
            end
            default: begin
              // saturated step, count and leds hold
            end
          endcase
        end
      end
      default: begin
        // unused command, state holds
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/countdown_timer_with_digit_set_core.sv
// countdown timer top level: input stage, state update and result register
// depends on ctdn_pkg, ctdn_in_stage, ctdn_update
// result path: input register, then result register; out_stall can hold an item in the input register
// throughput: one item per cycle while out_stall does not hold the result; the state update is combinational
// reset: synchronous active-low rst_n; count cleared, running, leds 0x80
`default_nettype none

module countdown_timer_with_digit_set_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ctdn_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ctdn_pkg::out_item_t      out_data
);
  import ctdn_pkg::*;

  // result register free this cycle, or being taken
  logic advance;
  stage_t stage;

  timer_state_t state_r;
  timer_state_t state_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      fire;

  assign advance = !out_valid_r || !out_stall;
  assign fire    = stage.valid && advance;

  // input register; stalls only when its item cannot move on
  ctdn_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  // next state for the registered item
  ctdn_update u_upd (
    .cur  (state_r),
    .item (stage.item),
    .nxt  (state_nxt)
  );

  // timer state only moves when an item is handed to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.paused     <= 1'b0;
      state_r.set_step   <= 3'd0;
      state_r.hundredths <= 7'd0;
      state_r.secs       <= 6'd0;
      state_r.mins       <= 6'd0;
      state_r.leds       <= LED_RUNNING;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, snapshot of the state after the item
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.minutes_left    <= state_nxt.mins;
      out_data_r.seconds_left    <= state_nxt.secs;
      out_data_r.hundredths_left <= state_nxt.hundredths;
      out_data_r.led_pattern     <= state_nxt.leds;
      out_data_r.running_flag    <= !state_nxt.paused;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hdl/ctdn_checker.sv
// port-level checks for the countdown timer, bound to the top level
// depends on ctdn_pkg and countdown_timer_with_digit_set_core_macros.svh
`default_nettype none
`include "countdown_timer_with_digit_set_core_macros.svh"

module ctdn_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ctdn_pkg::out_item_t out_data
);
  import ctdn_pkg::*;

  // stalled result holds
  `CTDN_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // count digits stay in range
  `CTDN_ASSERT(a_count_range, out_valid |-> out_data.minutes_left <= 6'd59 && out_data.seconds_left <= 6'd59 && out_data.hundredths_left <= 7'd100, "count digit out of range")

  // leds one-hot and running led matches the running flag
  `CTDN_ASSERT(a_led_mode, out_valid |-> $onehot(out_data.led_pattern) && (out_data.running_flag == out_data.led_pattern[7]), "led pattern inconsistent with mode")

  // no result right after reset
  `CTDN_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind countdown_timer_with_digit_set_core ctdn_checker u_ctdn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
